@@ rtl/lrfzd_pkg.sv @@
// Package for the lidar region filter: shared constants, types and the
// CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package lrfzd_pkg;
    localparam int ZONE_SLOTS_DEF   = 8;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic [14:0] HALF_X_RESET = 15'd950;
    localparam logic [14:0] HALF_Y_RESET = 15'd1450;
    localparam int VW = 36;   // CORDIC vector width
    localparam int ZW = 33;   // residual angle width

    localparam logic [2:0] REG_POSE_X  = 3'd0;
    localparam logic [2:0] REG_POSE_Y  = 3'd1;
    localparam logic [2:0] REG_HEADING = 3'd2;
    localparam logic [2:0] REG_START   = 3'd3;
    localparam logic [2:0] REG_STEP    = 3'd4;
    localparam logic [2:0] REG_HALF_X  = 3'd5;
    localparam logic [2:0] REG_HALF_Y  = 3'd6;

    // Queue entry between front and back
    typedef struct packed {
        logic        is_zone;
        logic [15:0] range_mm;
        logic        finite;
        logic [15:0] theta;
        logic [2:0]  zone_slot;
        logic [1:0]  zone_corner;
        logic [15:0] zone_coord;
    } job_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
                5'd20: r = 32'd652;       5'd21: r = 32'd326;
                5'd22: r = 32'd163;       5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction
endpackage

@@ rtl/lrfzd_front.sv @@
// Front end: accepts items, keeps the beam angle, forms queue entries.
// Depends on lrfzd_pkg.
`timescale 1ns / 1ps
module lrfzd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              kind,
    input  logic [15:0]       range_mm,
    input  logic              range_finite,
    input  logic              first_of_scan,
    input  logic [2:0]        zone_slot,
    input  logic [1:0]        zone_corner,
    input  logic signed [15:0] zone_coord_mm,
    input  logic [15:0]       heading,
    input  logic [15:0]       start_angle,
    input  logic [15:0]       angle_step,
    output logic              q_valid,
    output lrfzd_pkg::job_t   q_job,
    input  logic              q_take
);
    logic [15:0] beam_reg, beam_next;
    logic [15:0] beam_use;
    logic [1:0]  cnt_reg, cnt_next;
    lrfzd_pkg::job_t fifo_mem [2];
    logic rd_reg, wr_reg;
    logic acc;
    lrfzd_pkg::job_t new_job;

    assign full    = (cnt_reg == 2'd2);
    assign acc     = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job   = fifo_mem[rd_reg];

    // Pick the angle for this sample
    always_comb
    begin
        beam_use = first_of_scan ? start_angle : beam_reg;
        beam_next = beam_reg;
        if (acc && !kind)
            beam_next = beam_use + angle_step;
        new_job.is_zone     = kind;
        new_job.range_mm    = range_mm;
        new_job.finite      = range_finite;
        new_job.theta       = beam_use + heading;
        new_job.zone_slot   = zone_slot;
        new_job.zone_corner = zone_corner;
        new_job.zone_coord  = zone_coord_mm;
        cnt_next = cnt_reg + {1'b0, acc} - {1'b0, q_take};
    end

    // Advance angle and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_reg <= '0;
            cnt_reg  <= '0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
        end
        else
        begin
            beam_reg <= beam_next;
            cnt_reg  <= cnt_next;
            if (acc)
                wr_reg <= !wr_reg;
            if (q_take)
                rd_reg <= !rd_reg;
        end
    end

    // Hold queue entries
    always_ff @(posedge clk)
    begin
        if (acc)
            fifo_mem[wr_reg] <= new_job;
    end
endmodule

@@ rtl/lrfzd_back.sv @@
// Back end: iterative CORDIC, pose add, box test, zone scan, result register.
// Depends on lrfzd_pkg.
`timescale 1ns / 1ps
module lrfzd_back #(
    parameter int ZONE_SLOTS   = lrfzd_pkg::ZONE_SLOTS_DEF,
    parameter int CORDIC_STEPS = lrfzd_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  lrfzd_pkg::job_t   q_job,
    output logic              q_take,
    input  logic signed [15:0] pose_x,
    input  logic signed [15:0] pose_y,
    input  logic [14:0]       half_x,
    input  logic [14:0]       half_y,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       filtered_range_mm,
    output logic              filtered_valid,
    output logic              zone_changed,
    output logic [7:0]        zone_mask
);
    localparam int VW = lrfzd_pkg::VW;
    localparam int ZW = lrfzd_pkg::ZW;
    localparam int ZB = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int CB = $clog2(ZONE_SLOTS + 1);
    localparam int SB = 5;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_ROT  = 6'b000010, S_POSE = 6'b000100,
        S_BOX  = 6'b001000, S_SCAN = 6'b010000, S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic signed [VW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [SB-1:0] step_reg;
    logic [1:0] quad_reg;
    logic [15:0] range_reg;
    logic signed [15:0] px_reg, py_reg;
    logic [CB-1:0] cur_reg;
    logic [ZB-1:0] zi_reg;
    logic valid_reg, chg_reg;
    logic [7:0] mask_reg;
    logic out_full_reg;
    logic signed [15:0] zb_mem [ZONE_SLOTS*4];
    logic signed [15:0] zx0, zy0, zx1, zy1;

    assign empty = !out_full_reg;
    assign q_take = (state_reg == S_IDLE) && q_valid;

    // Zone table reads (one rectangle per cycle)
    assign zx0 = zb_mem[{zi_reg, 2'd0}];
    assign zy0 = zb_mem[{zi_reg, 2'd1}];
    assign zx1 = zb_mem[{zi_reg, 2'd2}];
    assign zy1 = zb_mem[{zi_reg, 2'd3}];

    logic signed [VW-1:0] dx, dy, rx, ry;
    logic signed [VW:0] sx, sy;
    logic signed [17:0] cx, cy, ax, ay;
    logic signed [15:0] satx, saty;
    logic signed [16:0] hx_s, hy_s;
    logic hit, is_cur, in_box;
    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        case (quad_reg)
            2'd0: begin rx = x_reg;  ry = y_reg;  end
            2'd1: begin rx = -y_reg; ry = x_reg;  end
            2'd2: begin rx = -x_reg; ry = -y_reg; end
            default: begin rx = y_reg; ry = -x_reg; end
        endcase
        sx = ({rx[VW-1], rx} + (VW+1)'(32768)) >>> 16;
        sy = ({ry[VW-1], ry} + (VW+1)'(32768)) >>> 16;
        cx = sx[17:0];
        cy = sy[17:0];
        ax = cx + 18'(pose_x);
        ay = cy + 18'(pose_y);
        satx = (ax > 18'sd32767) ? 16'sh7FFF : (ax < -18'sd32768) ? 16'sh8000 : ax[15:0];
        saty = (ay > 18'sd32767) ? 16'sh7FFF : (ay < -18'sd32768) ? 16'sh8000 : ay[15:0];
        hx_s = $signed({2'b00, half_x});
        hy_s = $signed({2'b00, half_y});
        in_box = (17'(px_reg) >= -hx_s) && (17'(px_reg) <= hx_s)
              && (17'(py_reg) >= -hy_s) && (17'(py_reg) <= hy_s);
        hit = (px_reg >= zx0) && (px_reg < zx1) && (py_reg >= zy0) && (py_reg < zy1);
        is_cur = (CB'(zi_reg) == cur_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid && !q_job.is_zone)
                        state_next = q_job.finite ? S_ROT : S_OUT;
            S_ROT:  if (step_reg == SB'(CORDIC_STEPS - 1)) state_next = S_POSE;
            S_POSE: state_next = S_BOX;
            S_BOX:  state_next = in_box ? S_SCAN : S_OUT;
            S_SCAN: if ((hit && !is_cur) || zi_reg == ZB'(ZONE_SLOTS - 1))
                        state_next = S_OUT;
            S_OUT:  if (!out_full_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= CB'(ZONE_SLOTS);
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCAN && hit && !is_cur)
                cur_reg <= CB'(zi_reg);
            if (state_reg == S_OUT && !out_full_reg)
                out_full_reg <= 1'b1;
            else if (pop && out_full_reg)
                out_full_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg     <= VW'(q_job.range_mm) * VW'(lrfzd_pkg::INV_GAIN_Q16);
                y_reg     <= '0;
                z_reg     <= ZW'({q_job.theta[13:0], 16'd0});
                quad_reg  <= q_job.theta[15:14];
                range_reg <= q_job.range_mm;
                step_reg  <= '0;
                zi_reg    <= '0;
                valid_reg <= 1'b0;
                chg_reg   <= 1'b0;
                mask_reg  <= '0;
            end
            S_ROT:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - dx; y_reg <= y_reg + dy;
                    z_reg <= z_reg - ZW'(lrfzd_pkg::atan_lut(step_reg));
                end
                else
                begin
                    x_reg <= x_reg + dx; y_reg <= y_reg - dy;
                    z_reg <= z_reg + ZW'(lrfzd_pkg::atan_lut(step_reg));
                end
                step_reg <= step_reg + 1'b1;
            end
            S_POSE:
            begin
                px_reg <= satx;
                py_reg <= saty;
                valid_reg <= 1'b1;
            end
            S_BOX:
                valid_reg <= in_box;
            S_SCAN:
            begin
                if (hit && !is_cur)
                begin
                    chg_reg  <= 1'b1;
                    mask_reg <= 8'(16'd1 << zi_reg);
                end
                zi_reg <= zi_reg + 1'b1;
            end
            default: ;
        endcase
        if (state_reg == S_OUT && !out_full_reg)
        begin
            filtered_range_mm <= valid_reg ? range_reg : 16'd0;
            filtered_valid    <= valid_reg;
            zone_changed      <= chg_reg;
            zone_mask         <= mask_reg;
        end
    end

    // Hold zone table; clear it at reset to empty rectangles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ZONE_SLOTS*4; i++)
                zb_mem[i] <= '0;
        end
        else if (q_take && q_job.is_zone && 32'(q_job.zone_slot) < ZONE_SLOTS)
        begin
            zb_mem[{ZB'(q_job.zone_slot), q_job.zone_corner}] <= q_job.zone_coord;
        end
    end
endmodule

@@ rtl/lidar_region_filter_zone_detect.sv @@
// Top level of the lidar region filter with zone detection.
// Depends on lrfzd_pkg, lrfzd_front, lrfzd_back.
//
// channel | handshake        | payload
// input   | push / full      | kind range_mm range_finite first_of_scan zone_*
// result  | empty / pop      | filtered_range_mm filtered_valid zone_changed zone_mask
// config  | cfg_valid/ready  | cfg_index cfg_data
//
// A finite sample runs in the back end through the CORDIC rotation (one step a cycle),
// the pose add, the box test and, inside the box, a scan of up to ZONE_SLOTS zones
// (one zone rectangle per cycle) before its result is registered.
// Zone writes go into the table when taken; non-finite samples go straight to the result.
// Reset clears control state and the zone table; the two-entry queue lets the front
// accept while the back end stalls on a waiting result.
`timescale 1ns / 1ps
module lidar_region_filter_zone_detect #(
    parameter int ZONE_SLOTS   = lrfzd_pkg::ZONE_SLOTS_DEF,
    parameter int CORDIC_STEPS = lrfzd_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              kind,
    input  logic [15:0]       range_mm,
    input  logic              range_finite,
    input  logic              first_of_scan,
    input  logic [2:0]        zone_slot,
    input  logic [1:0]        zone_corner,
    input  logic signed [15:0] zone_coord_mm,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       filtered_range_mm,
    output logic              filtered_valid,
    output logic              zone_changed,
    output logic [7:0]        zone_mask,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    logic signed [15:0] pose_x_reg, pose_y_reg;
    logic [15:0] heading_reg, start_reg, step_reg;
    logic [14:0] half_x_reg, half_y_reg;
    logic q_valid, q_take;
    lrfzd_pkg::job_t q_job;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg  <= '0;
            pose_y_reg  <= '0;
            heading_reg <= '0;
            start_reg   <= '0;
            step_reg    <= '0;
            half_x_reg  <= lrfzd_pkg::HALF_X_RESET;
            half_y_reg  <= lrfzd_pkg::HALF_Y_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lrfzd_pkg::REG_POSE_X:  pose_x_reg  <= cfg_data;
                lrfzd_pkg::REG_POSE_Y:  pose_y_reg  <= cfg_data;
                lrfzd_pkg::REG_HEADING: heading_reg <= cfg_data;
                lrfzd_pkg::REG_START:   start_reg   <= cfg_data;
                lrfzd_pkg::REG_STEP:    step_reg    <= cfg_data;
                lrfzd_pkg::REG_HALF_X:  half_x_reg  <= cfg_data[14:0];
                lrfzd_pkg::REG_HALF_Y:  half_y_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    lrfzd_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .range_mm(range_mm), .range_finite(range_finite),
        .first_of_scan(first_of_scan), .zone_slot(zone_slot),
        .zone_corner(zone_corner), .zone_coord_mm(zone_coord_mm),
        .heading(heading_reg), .start_angle(start_reg), .angle_step(step_reg),
        .q_valid(q_valid), .q_job(q_job), .q_take(q_take)
    );

    lrfzd_back #(.ZONE_SLOTS(ZONE_SLOTS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_job(q_job), .q_take(q_take),
        .pose_x(pose_x_reg), .pose_y(pose_y_reg), .half_x(half_x_reg),
        .half_y(half_y_reg), .empty(empty), .pop(pop),
        .filtered_range_mm(filtered_range_mm), .filtered_valid(filtered_valid),
        .zone_changed(zone_changed), .zone_mask(zone_mask)
    );
endmodule
